/* rtl/bac_pkg.sv */
// Shared types, command codes and constants of the BCD alarm clock.
package bac_pkg;

	localparam int unsigned SEC_W = 17;
	localparam int unsigned BCD_W = 22;
	localparam int unsigned TPS_W = 16;
	localparam int unsigned MIN_W = 16;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned ACC_W = 22;
	localparam int unsigned STEP_W = 3;
	localparam int unsigned MULT_W = 19;

	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET_TIME = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_ALARM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SNOOZE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ALARM_EN = 3'd4;

	localparam logic [SEC_W-1:0] DAY_SECONDS = 17'd86400;
	localparam logic [SEC_W-1:0] LAST_SECOND = 17'd86399;
	localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

	// Digit conversion runs hour tens first, second ones last.
	localparam logic [STEP_W-1:0] CONV_FIRST = 3'd0;
	localparam logic [STEP_W-1:0] CONV_LAST = 3'd5;
	// Modulo reduction subtracts one day times 32, 16, ... 1.
	localparam logic [STEP_W-1:0] MOD_FIRST = 3'd5;
	localparam logic [STEP_W-1:0] MOD_LAST = 3'd0;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [BCD_W-1:0] time_bcd;
		logic [MIN_W-1:0] snooze_minutes;
		logic             enable;
	} in_t;

	typedef struct packed {
		logic [BCD_W-1:0] time_now_bcd;
		logic             time_valid;
		logic [BCD_W-1:0] alarm_bcd;
		logic             alarm_set;
		logic             alarm_enabled;
		logic             alarm_fired;
		logic             accepted;
	} out_t;

	typedef struct packed {
		logic              capture;
		logic              decode;
		logic              mod_step;
		logic              apply;
		logic              conv_step;
		logic              load_out;
		logic [STEP_W-1:0] step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic snooze;
	} ctrl_sts_t;

	// Multiple m of the digit weight used at conversion step st.
	function automatic logic [MULT_W-1:0] digit_mult(input logic [STEP_W-1:0] st,
			input logic [3:0] m);
		logic [MULT_W-1:0] w;
		case (st)
			3'd0: w = 19'd36000;
			3'd1: w = 19'd3600;
			3'd2: w = 19'd600;
			3'd3: w = 19'd60;
			3'd4: w = 19'd10;
			default: w = 19'd1;
		endcase
		return MULT_W'(w * MULT_W'(m));
	endfunction

	// One day shifted left by the reduction step.
	function automatic logic [ACC_W-1:0] mod_weight(input logic [STEP_W-1:0] st);
		return ACC_W'({5'd0, DAY_SECONDS} << st);
	endfunction

endpackage

/* rtl/bac_ctrl.sv */
// Sequencer of the BCD alarm clock: word handshake and step control.
module bac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  bac_pkg::ctrl_sts_t  sts,
	output bac_pkg::ctrl_cmd_t  cmd
);
	import bac_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC = 3'd1;
	localparam logic [2:0] ST_MOD = 3'd2;
	localparam logic [2:0] ST_APPLY = 3'd3;
	localparam logic [2:0] ST_CONV = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.decode = (state_q == ST_DEC);
		cmd.mod_step = (state_q == ST_MOD);
		cmd.apply = (state_q == ST_APPLY);
		cmd.conv_step = (state_q == ST_CONV);
		cmd.load_out = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (sts.snooze) begin
						state_q <= ST_MOD;
						step_q <= MOD_FIRST;
					end else begin
						state_q <= ST_APPLY;
					end
				end
				ST_MOD: begin
					if (step_q == MOD_LAST) begin
						state_q <= ST_APPLY;
					end else begin
						step_q <= step_q - 3'd1;
					end
				end
				ST_APPLY: begin
					state_q <= ST_CONV;
					step_q <= CONV_FIRST;
				end
				ST_CONV: begin
					if (step_q == CONV_LAST) begin
						state_q <= ST_OUT;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_OUT: begin
					// hold until the output register can take the word
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/bac_dp.sv */
// Datapath of the BCD alarm clock: clock state, decode, modulo and BCD conversion.
module bac_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bac_pkg::in_t         in_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  bac_pkg::ctrl_cmd_t   cmd,
	output bac_pkg::ctrl_sts_t   sts,
	output bac_pkg::out_t        out_data
);
	import bac_pkg::*;

	in_t               in_q;
	out_t              out_q;
	logic [TPS_W-1:0]  tps_q;
	logic [TPS_W-1:0]  tick_count_q;
	logic [SEC_W-1:0]  sec_q;
	logic              time_set_q;
	logic [SEC_W-1:0]  alarm_q;
	logic              alarm_cfg_q;
	logic              alarm_on_q;
	logic [SEC_W-1:0]  dec_secs_q;
	logic              dec_ok_q;
	logic [ACC_W-1:0]  acc_q;
	logic              fired_q;
	logic              ok_q;
	logic [SEC_W-1:0]  rem_t_q;
	logic [SEC_W-1:0]  rem_a_q;
	logic [23:0]       t_bcd_q;
	logic [23:0]       a_bcd_q;

	// decode of the packed BCD input
	logic [1:0]        ht;
	logic [3:0]        ho, mt, mo, st, so;
	logic [5:0]        hours;
	logic              dec_ok;
	logic [SEC_W-1:0]  dec_secs;
	logic [ACC_W-1:0]  acc_init;
	logic [ACC_W-1:0]  mod_w;

	// next clock state
	logic [TPS_W-1:0]  tc_inc;
	logic              adv;
	logic [TPS_W-1:0]  n_tick;
	logic [SEC_W-1:0]  n_sec;
	logic              n_time_set;
	logic [SEC_W-1:0]  n_alarm;
	logic              n_cfg;
	logic              n_on;
	logic              n_fired;
	logic              n_ok;

	// one BCD digit per step on each remainder
	logic [3:0]        dig_t, dig_a;

	assign sts.snooze = (in_q.cmd == CMD_SNOOZE);

	always_comb begin
		ht = in_q.time_bcd[21:20];
		ho = in_q.time_bcd[19:16];
		mt = in_q.time_bcd[15:12];
		mo = in_q.time_bcd[11:8];
		st = in_q.time_bcd[7:4];
		so = in_q.time_bcd[3:0];
		hours = 6'(6'(ht) * 6'd10) + 6'(ho);
		dec_ok = (ho <= 4'd9) && (mt <= 4'd5) && (mo <= 4'd9) && (st <= 4'd5)
			&& (so <= 4'd9) && (hours < 6'd24);
		dec_secs = SEC_W'(SEC_W'(hours) * 17'd3600) + SEC_W'(SEC_W'(mt) * 17'd600)
			+ SEC_W'(SEC_W'(mo) * 17'd60) + SEC_W'(SEC_W'(st) * 17'd10) + SEC_W'(so);
		acc_init = ACC_W'(alarm_q) + ACC_W'(ACC_W'(in_q.snooze_minutes) * 22'd60);
		mod_w = mod_weight(cmd.step);
	end

	always_comb begin
		tc_inc = tick_count_q + 16'd1;
		adv = (tc_inc >= tps_q);
		n_tick = tick_count_q;
		n_sec = sec_q;
		n_time_set = time_set_q;
		n_alarm = alarm_q;
		n_cfg = alarm_cfg_q;
		n_on = alarm_on_q;
		n_fired = 1'b0;
		n_ok = 1'b0;
		case (in_q.cmd)
			CMD_TICK: begin
				n_ok = 1'b1;
				n_tick = adv ? '0 : tc_inc;
				if (adv) begin
					n_sec = (sec_q == LAST_SECOND) ? '0 : sec_q + 17'd1;
					n_fired = alarm_on_q && alarm_cfg_q && (n_sec == alarm_q);
				end
			end
			CMD_SET_TIME: begin
				if (dec_ok_q) begin
					n_sec = dec_secs_q;
					n_time_set = 1'b1;
					n_ok = 1'b1;
				end
			end
			CMD_SET_ALARM: begin
				if (dec_ok_q) begin
					n_alarm = dec_secs_q;
					n_cfg = 1'b1;
					n_ok = 1'b1;
				end
			end
			CMD_SNOOZE: begin
				if (alarm_cfg_q && (in_q.snooze_minutes != '0)) begin
					n_alarm = acc_q[SEC_W-1:0];
					n_ok = 1'b1;
				end
			end
			CMD_ALARM_EN: begin
				n_on = in_q.enable;
				n_ok = 1'b1;
			end
			default: begin
				n_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		dig_t = '0;
		dig_a = '0;
		for (int m = 1; m <= 9; m++) begin
			if ({2'b0, rem_t_q} >= digit_mult(cmd.step, 4'(m))) begin
				dig_t = 4'(m);
			end
			if ({2'b0, rem_a_q} >= digit_mult(cmd.step, 4'(m))) begin
				dig_a = 4'(m);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
			tick_count_q <= '0;
			sec_q <= '0;
			time_set_q <= 1'b0;
			alarm_q <= '0;
			alarm_cfg_q <= 1'b0;
			alarm_on_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tps_q <= cfg_data;
			end
			if (cmd.apply) begin
				tick_count_q <= n_tick;
				sec_q <= n_sec;
				time_set_q <= n_time_set;
				alarm_q <= n_alarm;
				alarm_cfg_q <= n_cfg;
				alarm_on_q <= n_on;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.decode) begin
			dec_secs_q <= dec_secs;
			dec_ok_q <= dec_ok;
			acc_q <= acc_init;
		end
		if (cmd.mod_step && (acc_q >= mod_w)) begin
			acc_q <= acc_q - mod_w;
		end
		if (cmd.apply) begin
			fired_q <= n_fired;
			ok_q <= n_ok;
			rem_t_q <= n_sec;
			rem_a_q <= n_alarm;
			t_bcd_q <= '0;
			a_bcd_q <= '0;
		end
		if (cmd.conv_step) begin
			rem_t_q <= rem_t_q - SEC_W'(digit_mult(cmd.step, dig_t));
			rem_a_q <= rem_a_q - SEC_W'(digit_mult(cmd.step, dig_a));
			t_bcd_q <= {t_bcd_q[19:0], dig_t};
			a_bcd_q <= {a_bcd_q[19:0], dig_a};
		end
		if (cmd.load_out) begin
			out_q.time_now_bcd <= t_bcd_q[BCD_W-1:0];
			out_q.time_valid <= time_set_q;
			out_q.alarm_bcd <= alarm_cfg_q ? a_bcd_q[BCD_W-1:0] : '0;
			out_q.alarm_set <= alarm_cfg_q;
			out_q.alarm_enabled <= alarm_on_q;
			out_q.alarm_fired <= fired_q;
			out_q.accepted <= ok_q;
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/bcd_alarm_clock_core.sv */
// Top level of the BCD alarm clock: sequencer plus datapath.
//
//   channel   signals                        direction  accepted when
//   in        in_valid, in_stall, in_data    to block   in_valid && !in_stall
//   out       out_valid, out_stall, out_data from block out_valid && !out_stall
//   cfg       cfg_we, cfg_data               to block   cfg_we
//
// Between acceptances a word passes decode, apply, the six-step digit conversion and the
// output load; a snooze word also runs the six-step modulo-one-day reduction after decode.
// The result waits in an output register, so the next word is taken while it stalls;
// a finished word holds in the sequencer only while that register is still full.
// Reset clears the clock, alarm and handshake state; the tick prescale limit resets to 1000.
module bcd_alarm_clock_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bac_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output bac_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data
);
	import bac_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	bac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bac_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
